@@ design/ccwc_pkg.sv @@
// shared types and constants for the coin change way counter
`default_nettype none

package ccwc_pkg;

    localparam int SUM_LIMIT_DEF = 1024;
    localparam int COIN_W        = 11;
    localparam int COUNT_W       = 32;

    typedef struct packed {
        logic [COIN_W-1:0] coin_value;
        logic              last_coin;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] way_count;
        logic               saturated;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RES,
        ST_LOAD
    } state_t;

endpackage

`default_nettype wire

@@ design/coin_change_ways_counter_top.sv @@
// coin change way counter: table of way counts updated one sum per cycle
//
// channels: input words (coin_value, last_coin) on in_valid/in_stall, result
// words (way_count, saturated) on out_valid/out_stall, and the target sum
// written on cfg_valid/cfg_ready (always ready; write only while idle).
// each coin walks the table from its value up to the target, one read-add-
// write per cycle through a single saturating adder and a two-read ram; a
// coin of zero or above the target leaves the table alone. on a word with
// last_coin set, the count at the target is read back and loaded into the
// output register in the load step once the output is free; the table is
// then swept back to its start contents. after reset the same sweep runs
// first (in_stall high).
// a stalled result holds in the output register; the block waits before
// loading the next result only if the previous one is still not taken.
`default_nettype none

module coin_change_ways_counter_top
    import ccwc_pkg::*;
#(
    parameter int SUM_LIMIT = SUM_LIMIT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_word_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_word_t              out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [COIN_W-1:0] cfg_data
);

    localparam int DEPTH = SUM_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((AW > COIN_W) ? AW : COIN_W) + 1;
    localparam logic [SW-1:0] LIMIT_S = SW'(SUM_LIMIT);
    localparam logic [AW-1:0] LIMIT_A = AW'(SUM_LIMIT);

    state_t state_reg, state_next;

    logic [COIN_W-1:0]  target_sum_reg;
    logic [SW-1:0]      coin_reg;
    logic               last_reg;
    logic [AW-1:0]      tgt_reg;
    logic [SW-1:0]      rd_s_reg;
    logic               wr_v_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic               fwd_reg;
    logic [COUNT_W-1:0] prev_wdata_reg;
    logic               ovf_reg;
    logic [AW-1:0]      clr_reg;
    logic               out_valid_reg;
    out_word_t          out_data_reg;

    logic [SW-1:0]      tgt_raw;
    logic [SW-1:0]      tgt_in;
    logic [SW-1:0]      coin_in;
    logic [SW-1:0]      diff_s;
    logic               accept;
    logic               issue;
    logic               out_free;
    logic [COUNT_W-1:0] b_op;
    logic [COUNT_W:0]   sum_wide;
    logic [COUNT_W-1:0] add_res;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic [COUNT_W-1:0] rdata_a;
    logic [COUNT_W-1:0] rdata_b;

    ccwc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // target clamped to the table size
    assign tgt_raw  = SW'(target_sum_reg);
    assign tgt_in   = (tgt_raw > LIMIT_S) ? LIMIT_S : tgt_raw;
    assign coin_in  = SW'(in_data.coin_value);
    assign diff_s   = rd_s_reg - coin_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign issue = (state_reg == ST_WALK) && (rd_s_reg <= SW'(tgt_reg));

    // with a coin of one the lower entry is written in the same cycle it is read, so it is forwarded
    assign b_op     = fwd_reg ? prev_wdata_reg : rdata_b;
    assign sum_wide = {1'b0, rdata_a} + {1'b0, b_op};
    assign add_res  = sum_wide[COUNT_W] ? {COUNT_W{1'b1}} : sum_wide[COUNT_W-1:0];

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = (clr_reg == '0) ? COUNT_W'(1) : '0;
        end
        else
        begin
            ram_we    = wr_v_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = add_res;
        end
        raddr_a = (state_reg == ST_WALK) ? rd_s_reg[AW-1:0] : tgt_reg;
        raddr_b = diff_s[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LIMIT_A)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((coin_in != '0) && (coin_in <= tgt_in))
                    begin
                        state_next = ST_WALK;
                    end
                    else if (in_data.last_coin)
                    begin
                        state_next = ST_RES;
                    end
                end
            end
            ST_WALK:
            begin
                if (!issue)
                begin
                    state_next = last_reg ? ST_RES : ST_IDLE;
                end
            end
            ST_RES:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            target_sum_reg <= '0;
            wr_v_reg       <= 1'b0;
            fwd_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                target_sum_reg <= cfg_data;
            end
            wr_v_reg <= issue;
            fwd_reg  <= issue && (coin_reg == SW'(1)) && wr_v_reg;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            else
            begin
                clr_reg <= '0;
            end
            if ((state_reg == ST_LOAD) && out_free)
            begin
                out_valid_reg <= 1'b1;
                ovf_reg       <= 1'b0;
            end
            else
            begin
                if (!out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (wr_v_reg && sum_wide[COUNT_W])
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coin_reg <= coin_in;
            last_reg <= in_data.last_coin;
            tgt_reg  <= tgt_in[AW-1:0];
            rd_s_reg <= coin_in;
        end
        else if (issue)
        begin
            rd_s_reg <= rd_s_reg + SW'(1);
        end
        wr_addr_reg <= rd_s_reg[AW-1:0];
        if (wr_v_reg)
        begin
            prev_wdata_reg <= add_res;
        end
        if ((state_reg == ST_LOAD) && out_free)
        begin
            out_data_reg.way_count <= rdata_a;
            out_data_reg.saturated <= ovf_reg;
        end
    end

    // no table update while waiting for a word
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("table written while idle");

    // a new result only comes out of the load step
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOAD))
        else $error("result raised outside load step");

    // forwarding is only for the unit coin
    a_fwd_unit_coin: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> (coin_reg == SW'(1)) && wr_v_reg)
        else $error("forwarding without unit coin");

    // walk writes stay at or below the target
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_v_reg && (state_reg != ST_CLEAR)) |-> (wr_addr_reg <= tgt_reg))
        else $error("walk write beyond target");

endmodule

`default_nettype wire

@@ design/ccwc_ram.sv @@
// generic ram: one write port, two read ports with registered read data
`default_nettype none

module ccwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    output logic      [WIDTH-1:0] rdata_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

@@ bench/coin_change_ways_counter_top_test.sv @@
// self-checking bench for the coin change way counter, with its own way table model
module coin_change_ways_counter_top_test;
    import ccwc_pkg::*;

    localparam int LIMIT        = SUM_LIMIT_DEF;
    localparam int RANDOM_ITEMS = 550;
    // one full walk, result load and table sweep, with margin
    localparam int DRAIN_CYCLES = 2 * LIMIT + 64;
    localparam int HOLD_CYCLES  = 4000;
    localparam int QUIET_LIMIT  = 40000;
    localparam int IDLE_PCT     = 37;

    class ways_scoreboard;
        bit [COUNT_W-1:0] ways [LIMIT+1];
        bit               sat_seen;
        bit [COIN_W-1:0]  target;
        out_word_t        expected_counts [$];
        int               errors;

        function new();
            target = '0;
            errors = 0;
            clear_ways();
        endfunction

        function void clear_ways();
            foreach (ways[i])
                ways[i] = '0;
            ways[0]  = 1;
            sat_seen = 1'b0;
        endfunction

        function void set_target(bit [COIN_W-1:0] value);
            target = value;
        endfunction

        // targets above the table size are clamped
        function int reach();
            return (int'(target) > LIMIT) ? LIMIT : int'(target);
        endfunction

        function void apply_coin(in_word_t w);
            int            top;
            int            c;
            bit [COUNT_W:0] s;
            out_word_t     e;
            top = reach();
            c   = int'(w.coin_value);
            if (c != 0 && c <= top)
            begin
                for (int i = c; i <= top; i++)
                begin
                    s = {1'b0, ways[i]} + {1'b0, ways[i - c]};
                    if (s[COUNT_W])
                    begin
                        ways[i]  = '1;
                        sat_seen = 1'b1;
                    end
                    else
                        ways[i] = s[COUNT_W-1:0];
                end
            end
            if (w.last_coin)
            begin
                e.way_count = ways[top];
                e.saturated = sat_seen;
                expected_counts.push_back(e);
                clear_ways();
            end
        endfunction

        function void check_count(out_word_t got);
            out_word_t e;
            if (expected_counts.size() == 0)
            begin
                $error("result word with nothing expected: way_count %0d saturated %0b",
                       got.way_count, got.saturated);
                errors++;
                return;
            end
            e = expected_counts.pop_front();
            if (got.way_count !== e.way_count)
            begin
                $error("way_count: expected %0d, got %0d", e.way_count, got.way_count);
                errors++;
            end
            if (got.saturated !== e.saturated)
            begin
                $error("saturated: expected %0b, got %0b", e.saturated, got.saturated);
                errors++;
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    in_word_t        in_data;
    logic            out_valid;
    logic            out_stall;
    out_word_t       out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [COIN_W-1:0] cfg_data;

    ways_scoreboard sb = new();
    bit             steady;
    bit             hold_req;
    int             hold_left;
    int             items_sent;

    coin_change_ways_counter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_coin(input logic [COIN_W-1:0] coin, input logic last);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = '{coin_value: coin, last_coin: last};
        do
            @(posedge clk);
        while (in_stall);
        sb.apply_coin(in_data);
        items_sent++;
    endtask

    // block must be idle: all results in, then a full walk and sweep let pass
    task automatic change_target(input logic [COIN_W-1:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_target(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [COIN_W-1:0] pick_target();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return COIN_W'($urandom_range(0, 60));
        else if (r < 85)
            return COIN_W'($urandom_range(61, 300));
        else if (r < 93)
            return COIN_W'($urandom_range(301, LIMIT));
        else
            return COIN_W'($urandom_range(LIMIT + 1, 2047));
    endfunction

    initial
    begin : result_side
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_count(out_data);
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (steady)
                out_stall = 1'b0;
            else
                out_stall = ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int               n_coins;
        int               r;
        int               top;
        int               base;
        bit               hold_done;
        logic [COIN_W-1:0] coin;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero target after reset: only the empty combination
        send_coin(1, 1'b1);
        // zero coin and an oversized coin leave the table alone
        change_target(10);
        send_coin(0, 1'b0);
        send_coin(11'h7FF, 1'b0);
        send_coin(1, 1'b0);
        send_coin(2, 1'b0);
        send_coin(5, 1'b1);
        // largest target, enough small coins to saturate
        change_target(COIN_W'(LIMIT));
        for (int k = 1; k <= 6; k++)
            send_coin(COIN_W'(k), k == 6);
        // target above the table size is clamped
        change_target(11'h7FF);
        send_coin(1023, 1'b0);
        send_coin(1024, 1'b1);
        change_target(1);
        send_coin(1, 1'b1);
        // target moved in the middle of a set
        change_target(20);
        send_coin(3, 1'b0);
        change_target(30);
        send_coin(7, 1'b1);

        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            steady = (items_sent >= base + 180) && (items_sent < base + 290);
            if (!hold_done && items_sent >= base + 360)
            begin
                // small sets while the result side holds off, so the block backs up
                change_target(12);
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            else if (!hold_req && hold_left == 0 && $urandom_range(1) == 1)
                change_target(pick_target());
            n_coins = $urandom_range(1, 6);
            top     = sb.reach();
            for (int k = 1; k <= n_coins; k++)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    coin = (top == 0) ? COIN_W'(1) : COIN_W'($urandom_range(1, top));
                else if (r < 85)
                    coin = COIN_W'($urandom_range(1, 8));
                else
                    coin = COIN_W'($urandom_range(0, 2047));
                send_coin(coin, k == n_coins);
            end
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
